>>> hdl/mrsc_pkg.sv
package mrsc_pkg;

	localparam int COUNT_WIDTH = 24;
	localparam int TIME_WIDTH = 32;

	localparam int CMD_W = 2;
	localparam int FT_W = 23;
	localparam int LVL_W = 16;
	localparam int RAMP_W = 16;
	localparam int CFG_W = FT_W;
	localparam int CFG_IDX_W = 2;

	localparam int QB = 16;
	localparam int DIV_W = FT_W + 5;
	localparam int QCNT_W = $clog2(QB + 1);

	localparam int WIDE_W = ((COUNT_WIDTH > FT_W) ? COUNT_WIDTH : FT_W) + 10;
	localparam int SPD_W = ((COUNT_WIDTH + 6 > TIME_WIDTH + 3) ?
		(COUNT_WIDTH + 6) : (TIME_WIDTH + 3)) + 1;
	localparam int PROD_W = 2 * (LVL_W + 1);

	localparam int IN_BITS = TIME_WIDTH + COUNT_WIDTH + 1;
	localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = 2 * LVL_W + 1;
	localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam int TICK_MIN_MS = 6;
	localparam int STALL_MS = 1500;
	localparam logic [LVL_W-1:0] LEVEL_FULL = '1;

	localparam logic [FT_W-1:0] TRAVEL_RESET = FT_W'(1000);
	localparam logic [LVL_W-1:0] BRAKE_RESET = '0;
	localparam logic [RAMP_W-1:0] RAMP_RESET = RAMP_W'(500);

	typedef enum logic [CMD_W-1:0] {
		CMD_START = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_STOP  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRAVEL = 2'd0,
		REG_BRAKE  = 2'd1,
		REG_RAMP   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [FT_W-1:0]   travel;
		logic [LVL_W-1:0]  brake;
		logic [RAMP_W-1:0] ramp;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic          done;
		logic [QB-1:0] quo;
	} div_rsp_t;

endpackage

>>> hdl/motor_ramp_and_stall_controller.sv
// Each request gives exactly one result. Its work runs through one shared 16-step restoring
// divider: a control tick in the ramp or in the braking zone uses it at most once for the
// level, and every request with a position strictly inside the travel uses it once more
// for the position, while the braking curve uses one shared 17 by 17 bit multiplier. The
// block takes no new request while one is being worked on, but a finished result may wait
// in its output register while the next request is accepted. A full travel count of zero
// is treated as one.
module motor_ramp_and_stall_controller (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mrsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mrsc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// now_ms, encoder_count, reverse
	input  logic [mrsc_pkg::S_TDATA_W-1:0] s_tdata,
	// cmd
	input  logic [mrsc_pkg::CMD_W-1:0]     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// drive_level, still_moving, position
	output logic [mrsc_pkg::M_TDATA_W-1:0] m_tdata
);
	import mrsc_pkg::*;

	logic [FT_W-1:0]   travel_q;
	logic [LVL_W-1:0]  brake_q;
	logic [RAMP_W-1:0] ramp_q;
	cfg_t              cfg;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			travel_q <= TRAVEL_RESET;
			brake_q <= BRAKE_RESET;
			ramp_q <= RAMP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TRAVEL: travel_q <= cfg_data[FT_W-1:0];
				REG_BRAKE:  brake_q <= cfg_data[LVL_W-1:0];
				REG_RAMP:   ramp_q <= cfg_data[RAMP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.travel = (travel_q == '0) ? FT_W'(1) : travel_q;
	assign cfg.brake = brake_q;
	assign cfg.ramp = ramp_q;

	mrsc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	mrsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.div_req  (div_req),
		.div_rsp  (div_rsp)
	);

endmodule

>>> hdl/mrsc_div.sv
module mrsc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  mrsc_pkg::div_req_t req,
	output mrsc_pkg::div_rsp_t rsp
);
	import mrsc_pkg::*;

	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  den_q;
	logic [QB-1:0]     quo_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_W:0]    shifted;
	logic              fits;
	logic [DIV_W:0]    diff;

	// Restoring division, one quotient bit per cycle; the remainder always stays below den.
	assign shifted = {rem_q, 1'b0};
	assign fits = shifted >= {1'b0, den_q};
	assign diff = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= QCNT_W'(QB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == QCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
			quo_q <= {quo_q[QB-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;

endmodule

>>> hdl/mrsc_ctrl.sv
module mrsc_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mrsc_pkg::cfg_t                 cfg,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [mrsc_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [mrsc_pkg::CMD_W-1:0]     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [mrsc_pkg::M_TDATA_W-1:0] m_tdata,
	output mrsc_pkg::div_req_t             div_req,
	input  mrsc_pkg::div_rsp_t             div_rsp
);
	import mrsc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_SCALE,
		ST_DECIDE,
		ST_RDIV,
		ST_SQR,
		ST_BRK,
		ST_LVL,
		ST_PSTART,
		ST_PDIV,
		ST_OUT
	} state_t;

	state_t state_q;

	cmd_t                   cmd_q;
	logic [TIME_WIDTH-1:0]  now_q;
	logic [COUNT_WIDTH-1:0] enc_q;
	logic                   rev_q;

	logic                   ramp_act_q;
	logic [TIME_WIDTH-1:0]  ramp_start_q;
	logic [COUNT_WIDTH-1:0] last_cnt_q;
	logic [TIME_WIDTH-1:0]  last_tick_q;
	logic [TIME_WIDTH-1:0]  last_motion_q;
	logic                   slow_q;
	logic [LVL_W-1:0]       lvl_q;
	logic                   moving_q;
	logic [LVL_W-1:0]       pos_q;
	logic                   div_ramp_q;
	logic [LVL_W:0]         t_q;
	div_req_t               div_req_q;
	logic                   out_valid_q;
	logic [M_TDATA_W-1:0]   out_data_q;

	logic [TIME_WIDTH-1:0]    dt_q;
	logic [TIME_WIDTH-1:0]    age_q;
	logic [TIME_WIDTH-1:0]    el_q;
	logic signed [COUNT_WIDTH:0] diff_q;
	logic signed [WIDE_W-1:0] c100_q;
	logic signed [WIDE_W-1:0] f80_q;
	logic signed [WIDE_W-1:0] f20_q;
	logic [DIV_W-1:0]         den17_q;
	logic                     pos_lo_q;
	logic                     pos_hi_q;
	logic signed [WIDE_W-1:0] num_q;
	logic signed [SPD_W-1:0]  d20_q;
	logic signed [SPD_W-1:0]  dt7_q;
	logic [PROD_W-1:0]        prod_q;

	logic signed [WIDE_W-1:0] c_w;
	logic signed [WIDE_W-1:0] f_w;
	logic signed [SPD_W-1:0]  d_w;
	logic signed [SPD_W-1:0]  dt_w;
	logic signed [SPD_W-1:0]  spd_sum;
	logic                     slow_now;
	logic                     slow_next;
	logic                     changed;
	logic                     recent;
	logic                     num_ge_den;
	logic [LVL_W:0]           mul_a;
	logic [LVL_W:0]           mul_b;
	logic                     in_take;

	assign in_take = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign div_req = div_req_q;

	assign c_w = WIDE_W'($signed(enc_q));
	assign f_w = $signed(WIDE_W'(cfg.travel));
	assign d_w = SPD_W'(diff_q);
	assign dt_w = $signed(SPD_W'(dt_q));

	// A negative difference is slow when 20*|d| < 7*dt, that is when 7*dt + 20*d > 0.
	assign spd_sum = dt7_q + d20_q;
	assign slow_now = d20_q[SPD_W-1] ? (!spd_sum[SPD_W-1] && (spd_sum != '0))
		: (d20_q < dt7_q);
	assign slow_next = slow_q || slow_now;
	assign changed = (diff_q != '0);
	assign recent = (age_q < TIME_WIDTH'(STALL_MS));
	assign num_ge_den = ($unsigned(num_q) >= WIDE_W'(den17_q));

	always_comb begin
		if (state_q == ST_SQR) begin
			mul_a = t_q;
			mul_b = t_q;
		end else begin
			mul_a = {1'b0, LEVEL_FULL - cfg.brake};
			mul_b = prod_q[2*LVL_W:LVL_W];
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_q <= cmd_t'(s_tuser);
			now_q <= s_tdata[TIME_WIDTH-1:0];
			enc_q <= s_tdata[TIME_WIDTH +: COUNT_WIDTH];
			rev_q <= s_tdata[TIME_WIDTH + COUNT_WIDTH];
		end
		if (state_q == ST_PREP) begin
			dt_q <= now_q - last_tick_q;
			age_q <= now_q - last_motion_q;
			el_q <= now_q - ramp_start_q;
			diff_q <= $signed({last_cnt_q[COUNT_WIDTH-1], last_cnt_q})
				- $signed({enc_q[COUNT_WIDTH-1], enc_q});
			c100_q <= (c_w <<< 6) + (c_w <<< 5) + (c_w <<< 2);
			f80_q <= (f_w <<< 6) + (f_w <<< 4);
			f20_q <= (f_w <<< 4) + (f_w <<< 2);
			den17_q <= (DIV_W'(cfg.travel) << 4) + DIV_W'(cfg.travel);
			pos_lo_q <= c_w[WIDE_W-1] || (c_w == '0);
			pos_hi_q <= (c_w >= f_w);
		end
		if (state_q == ST_SCALE) begin
			num_q <= rev_q ? (f20_q - c100_q) : (c100_q - f80_q);
			d20_q <= (d_w <<< 4) + (d_w <<< 2);
			dt7_q <= (dt_w <<< 3) - dt_w;
		end
		if (state_q == ST_SQR || state_q == ST_BRK) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ramp_act_q <= 1'b0;
			ramp_start_q <= '0;
			last_cnt_q <= '0;
			last_tick_q <= '0;
			last_motion_q <= '0;
			slow_q <= 1'b0;
			lvl_q <= '0;
			moving_q <= 1'b1;
			pos_q <= '0;
			div_ramp_q <= 1'b0;
			t_q <= '0;
			div_req_q <= '0;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
		end else begin
			if (out_valid_q && m_tready && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					unique case (cmd_q)
						CMD_START: begin
							ramp_act_q <= 1'b1;
							ramp_start_q <= now_q;
							last_cnt_q <= enc_q;
							last_tick_q <= now_q;
							last_motion_q <= now_q;
							moving_q <= 1'b1;
							state_q <= ST_PSTART;
						end
						CMD_STOP: begin
							lvl_q <= '0;
							ramp_act_q <= 1'b0;
							slow_q <= 1'b0;
							moving_q <= recent;
							state_q <= ST_PSTART;
						end
						CMD_TICK: begin
							if (dt_q >= TIME_WIDTH'(TICK_MIN_MS)) begin
								last_cnt_q <= enc_q;
								last_tick_q <= now_q;
								if (changed) begin
									last_motion_q <= now_q;
								end
								moving_q <= changed || recent;
								if (ramp_act_q) begin
									if (el_q >= TIME_WIDTH'(cfg.ramp)) begin
										lvl_q <= LEVEL_FULL;
										ramp_act_q <= 1'b0;
										state_q <= ST_PSTART;
									end else begin
										div_req_q.start <= 1'b1;
										div_req_q.num <= DIV_W'(el_q[RAMP_W-1:0]);
										div_req_q.den <= DIV_W'(cfg.ramp);
										div_ramp_q <= 1'b1;
										state_q <= ST_RDIV;
									end
								end else begin
									slow_q <= slow_next;
									if (slow_next) begin
										state_q <= ST_PSTART;
									end else if (num_q[WIDE_W-1]) begin
										lvl_q <= LEVEL_FULL;
										state_q <= ST_PSTART;
									end else if (num_ge_den) begin
										t_q <= {1'b1, {LVL_W{1'b0}}};
										state_q <= ST_SQR;
									end else begin
										div_req_q.start <= 1'b1;
										div_req_q.num <= num_q[DIV_W-1:0];
										div_req_q.den <= den17_q;
										div_ramp_q <= 1'b0;
										state_q <= ST_RDIV;
									end
								end
							end else begin
								moving_q <= 1'b1;
								state_q <= ST_PSTART;
							end
						end
						default: begin
							moving_q <= 1'b1;
							state_q <= ST_PSTART;
						end
					endcase
				end
				ST_RDIV: begin
					div_req_q.start <= 1'b0;
					if (div_rsp.done) begin
						if (div_ramp_q) begin
							lvl_q <= div_rsp.quo;
							state_q <= ST_PSTART;
						end else begin
							t_q <= {1'b0, div_rsp.quo};
							state_q <= ST_SQR;
						end
					end
				end
				ST_SQR: begin
					state_q <= ST_BRK;
				end
				ST_BRK: begin
					state_q <= ST_LVL;
				end
				ST_LVL: begin
					lvl_q <= LEVEL_FULL - prod_q[2*LVL_W-1:LVL_W];
					state_q <= ST_PSTART;
				end
				ST_PSTART: begin
					if (pos_lo_q) begin
						pos_q <= '0;
						state_q <= ST_OUT;
					end else if (pos_hi_q) begin
						pos_q <= LEVEL_FULL;
						state_q <= ST_OUT;
					end else begin
						div_req_q.start <= 1'b1;
						div_req_q.num <= DIV_W'(enc_q);
						div_req_q.den <= DIV_W'(cfg.travel);
						state_q <= ST_PDIV;
					end
				end
				ST_PDIV: begin
					div_req_q.start <= 1'b0;
					if (div_rsp.done) begin
						pos_q <= div_rsp.quo;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_data_q <= M_TDATA_W'({pos_q, moving_q, lvl_q});
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> test/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mrsc_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam logic [TIME_WIDTH-1:0] T0 = 32'hFFFF_FFC0;

	typedef struct packed {
		cmd_t                   cmd;
		logic [TIME_WIDTH-1:0]  now;
		logic [COUNT_WIDTH-1:0] count;
		logic                   rev;
	} motion_t;

	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic             moving;
		logic [LVL_W-1:0] pos;
	} drive_out_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [CMD_W-1:0]     s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	motor_ramp_and_stall_controller uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// Register copies and controller state as the predictor sees them.
	logic [FT_W-1:0]       travel_cfg = TRAVEL_RESET;
	logic [LVL_W-1:0]      brake_cfg = BRAKE_RESET;
	logic [RAMP_W-1:0]     ramp_cfg = RAMP_RESET;
	logic                  ramp_on = 1'b0;
	logic [TIME_WIDTH-1:0] ramp_t0 = '0;
	longint                prev_count = 0;
	logic [TIME_WIDTH-1:0] prev_tick = '0;
	logic [TIME_WIDTH-1:0] moved_at = '0;
	logic                  slow = 1'b0;
	logic [LVL_W-1:0]      level = '0;

	motion_t    motion_reqs[$];
	drive_out_t expected_drive[$];
	motion_t    next_req;
	drive_out_t want;

	logic [TIME_WIDTH-1:0] t_ms = '0;
	int  phase_items = 0;
	int  n_requests = 0;
	int  n_results = 0;
	int  n_stalls = 0;
	int  n_faults = 0;
	int  quiet_cycles = 0;
	int  hold_left = 0;
	bit  s_fire = 1'b0;
	bit  m_fire = 1'b0;
	bit  calm = 1'b0;
	bit  hold_ask = 1'b0;
	bit  hold_served = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint travel_span();
		return (travel_cfg == 0) ? 1 : longint'(travel_cfg);
	endfunction

	function automatic logic [LVL_W-1:0] travel_frac(longint c);
		longint f;
		f = travel_span();
		if (c <= 0)
			return '0;
		if (c >= f)
			return LEVEL_FULL;
		return LVL_W'((c << 16) / f);
	endfunction

	function automatic logic [LVL_W-1:0] brake_curve(longint c, logic rev);
		longint f, num, den, t16, s, gap;
		f = travel_span();
		den = 17 * f;
		if (rev) begin
			if (f < 5 * c)
				return LEVEL_FULL;
			num = 20 * f - 100 * c;
		end else begin
			if (5 * c < 4 * f)
				return LEVEL_FULL;
			num = 100 * c - 80 * f;
		end
		t16 = (num >= den) ? 65536 : (num << 16) / den;
		s = (t16 * t16) >> 16;
		gap = 65535 - longint'(brake_cfg);
		return LEVEL_FULL - LVL_W'((gap * s) >> 16);
	endfunction

	function automatic drive_out_t drive_step(motion_t it);
		drive_out_t r;
		longint c, d, ad, dtl, el;
		logic [TIME_WIDTH-1:0] dt, e;
		c = longint'($signed(it.count));
		r.moving = 1'b1;
		case (it.cmd)
		CMD_START: begin
			ramp_on = 1'b1;
			ramp_t0 = it.now;
			prev_count = c;
			prev_tick = it.now;
			moved_at = it.now;
		end
		CMD_STOP: begin
			level = '0;
			ramp_on = 1'b0;
			slow = 1'b0;
			dt = it.now - moved_at;
			r.moving = (dt < STALL_MS);
		end
		CMD_TICK: begin
			dt = it.now - prev_tick;
			if (dt >= TICK_MIN_MS) begin
				if (ramp_on) begin
					e = it.now - ramp_t0;
					if (e >= ramp_cfg) begin
						level = LEVEL_FULL;
						ramp_on = 1'b0;
					end else begin
						el = longint'(e);
						level = LVL_W'((el << 16) / longint'(ramp_cfg));
					end
				end else begin
					d = prev_count - c;
					ad = (d < 0) ? -d : d;
					dtl = longint'(dt);
					if (20 * ad < 7 * dtl)
						slow = 1'b1;
					if (!slow)
						level = brake_curve(c, it.rev);
				end
				if (prev_count != c)
					moved_at = it.now;
				prev_count = c;
				prev_tick = it.now;
				dt = it.now - moved_at;
				r.moving = (dt < STALL_MS);
			end
		end
		default: begin
		end
		endcase
		r.level = level;
		r.pos = travel_frac(c);
		return r;
	endfunction

	always @(posedge clk) begin
		s_fire = arst_n && s_tvalid && s_tready;
		m_fire = arst_n && m_tvalid && m_tready;
		if (m_fire) begin
			n_results++;
			if (!m_tdata[LVL_W])
				n_stalls++;
			if (expected_drive.size() == 0) begin
				n_faults++;
				$display("%0t: result with no request pending, expected none, got %h",
					$time, m_tdata);
			end else begin
				want = expected_drive.pop_front();
				if (m_tdata[LVL_W-1:0] !== want.level) begin
					n_faults++;
					$display("%0t: drive_level expected %0d, got %0d",
						$time, want.level, m_tdata[LVL_W-1:0]);
				end
				if (m_tdata[LVL_W] !== want.moving) begin
					n_faults++;
					$display("%0t: still_moving expected %0d, got %0d",
						$time, want.moving, m_tdata[LVL_W]);
				end
				if (m_tdata[2*LVL_W:LVL_W+1] !== want.pos) begin
					n_faults++;
					$display("%0t: position expected %0d, got %0d",
						$time, want.pos, m_tdata[2*LVL_W:LVL_W+1]);
				end
			end
		end
		if (s_fire) begin
			n_requests++;
			expected_drive.push_back(drive_step('{cmd: cmd_t'(s_tuser),
				now: s_tdata[TIME_WIDTH-1:0],
				count: s_tdata[TIME_WIDTH+COUNT_WIDTH-1:TIME_WIDTH],
				rev: s_tdata[TIME_WIDTH+COUNT_WIDTH]}));
		end
		if (s_fire || m_fire)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
			$display("tb: done, errors");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (!s_tvalid || s_fire) begin
			if (motion_reqs.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
				next_req = motion_reqs.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= S_TDATA_W'({next_req.rev, next_req.count, next_req.now});
				s_tuser <= next_req.cmd;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_ask && !hold_served) begin
			hold_left = HOLD_CYCLES;
			hold_served = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= 20);
		end
	end

	task automatic add(cmd_t cmd, logic [TIME_WIDTH-1:0] now, int cnt, logic rev);
		motion_reqs.push_back('{cmd: cmd, now: now, count: COUNT_WIDTH'(cnt), rev: rev});
		phase_items++;
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
		REG_TRAVEL: travel_cfg = val;
		REG_BRAKE:  brake_cfg = val[LVL_W-1:0];
		REG_RAMP:   ramp_cfg = val[RAMP_W-1:0];
		default: begin
		end
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_setting(int travel, int brake, int ramp);
		write_reg(REG_TRAVEL, CFG_W'(travel));
		write_reg(REG_BRAKE, CFG_W'(brake));
		write_reg(REG_RAMP, CFG_W'(ramp));
	endtask

	task automatic drain();
		while (motion_reqs.size() != 0 || expected_drive.size() != 0 || s_tvalid)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return $urandom_range(5);
		if (r < 85)
			return $urandom_range(6, 40);
		if (r < 95)
			return $urandom_range(41, 400);
		return $urandom_range(1000, 3000);
	endfunction

	// A movement: start, a series of ticks while the cover travels, then usually a stop.
	task automatic queue_run(int n);
		longint f, pos, step;
		logic rev, mixed;
		int dt, r;
		f = travel_span();
		rev = 1'($urandom_range(1));
		mixed = ($urandom_range(4) < 2);
		pos = rev ? f : 0;
		if ($urandom_range(3) == 0)
			pos = longint'($urandom_range(int'(f)));
		add(CMD_START, t_ms, int'(pos), rev);
		for (int i = 0; i < n; i++) begin
			dt = pick_gap();
			t_ms += dt;
			r = mixed ? $urandom_range(99) : 0;
			if (r < 75)
				step = f * $urandom_range(1, 3) / (2 * n) + (7 * dt) / 20 + 1;
			else if (r < 90)
				step = longint'($urandom_range((7 * dt) / 20));
			else
				step = 0;
			pos = rev ? pos - step : pos + step;
			if (pos > 8388607)
				pos = 8388607;
			if (pos < -8388608)
				pos = -8388608;
			add(CMD_TICK, t_ms, int'(pos), rev);
		end
		if (!mixed && $urandom_range(1)) begin
			t_ms += $urandom_range(1500, 2500);
			add(CMD_TICK, t_ms, int'(pos), rev);
		end
		if ($urandom_range(3) != 0) begin
			t_ms += $urandom_range(3000);
			add(CMD_STOP, t_ms, int'(pos), rev);
		end
	endtask

	task automatic fill_phase(int n);
		phase_items = 0;
		while (phase_items < n) begin
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(1, 3))
					add(cmd_t'($urandom_range(3)), $urandom, int'($urandom),
						1'($urandom_range(1)));
			end else begin
				queue_run($urandom_range(4, 16));
			end
		end
	endtask

	task automatic queue_directed();
		add(CMD_NOP,   T0,        -8388608, 1'b1);
		add(CMD_START, T0,        0,        1'b0);
		add(CMD_TICK,  T0 + 3,    10,       1'b0);
		add(CMD_TICK,  T0 + 10,   100,      1'b0);
		add(CMD_TICK,  T0 + 30,   300,      1'b0);
		add(CMD_TICK,  T0 + 50,   500,      1'b0);
		add(CMD_TICK,  T0 + 60,   700,      1'b0);
		add(CMD_TICK,  T0 + 70,   800,      1'b0);
		add(CMD_TICK,  T0 + 80,   900,      1'b0);
		add(CMD_TICK,  T0 + 90,   970,      1'b0);
		add(CMD_TICK,  T0 + 100,  1100,     1'b0);
		add(CMD_TICK,  T0 + 110,  1101,     1'b0);
		add(CMD_TICK,  T0 + 120,  1200,     1'b0);
		add(CMD_TICK,  T0 + 1700, 1200,     1'b0);
		add(CMD_STOP,  T0 + 1800, 1200,     1'b0);
		add(CMD_START, T0 + 2000, 1000,     1'b1);
		add(CMD_TICK,  T0 + 2010, 990,      1'b1);
		add(CMD_TICK,  T0 + 2060, 800,      1'b1);
		add(CMD_TICK,  T0 + 2070, 250,      1'b1);
		add(CMD_TICK,  T0 + 2080, 200,      1'b1);
		add(CMD_TICK,  T0 + 2090, 30,       1'b1);
		add(CMD_TICK,  T0 + 2100, -8388608, 1'b1);
		add(CMD_TICK,  T0 + 2110, 8388607,  1'b1);
		add(CMD_STOP,  T0 + 2200, 8388607,  1'b1);
		add(CMD_TICK,  '0,        -1,       1'b0);
		t_ms = T0 + 3000;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		apply_setting(1000, 16384, 50);
		queue_directed();
		drain();
		for (int p = 0; p < 8; p++) begin
			case (p)
			0: apply_setting(1, 65535, 0);
			1: apply_setting(8388607, 0, 65535);
			2: apply_setting(0, 40000, 20);
			default: apply_setting(($urandom_range(3) == 0) ? $urandom_range(1, 8388607) :
				$urandom_range(1, 5000), $urandom_range(65535), $urandom_range(400));
			endcase
			calm = (p == 2);
			if (p == 1)
				hold_ask = 1'b1;
			fill_phase(60);
			drain();
		end
		calm = 1'b0;
		repeat (100) @(negedge clk);
		if (expected_drive.size() != 0) begin
			n_faults++;
			$display("%0t: %0d results never arrived", $time, expected_drive.size());
		end
		$display("tb: %0d requests sent, %0d results checked over 9 register settings",
			n_requests, n_results);
		$display("tb: %0d stall reports seen, %0d mismatches", n_stalls, n_faults);
		if (n_faults == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
